// File: hdl/hsa_pkg.sv
// ----------------------------------------------------------------------------
// hsa_pkg
// shared constants, coefficient set and front-to-back job type
// ----------------------------------------------------------------------------
package hsa_pkg;

    localparam int IMAGE_COLS = 188;
    localparam int IMAGE_ROWS = 120;

    localparam int COL_W    = 8;
    localparam int ROW_W    = 7;
    localparam int COEF_W   = 32;
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 3;
    localparam int DATA_W   = 16;

    // 32b coef times 8b coord plus two more terms stays below 2^40
    localparam int SUM_W = 42;
    localparam int MAG_W = SUM_W - 1;

    localparam int Q_ONE = 2 ** 24;

    // quotient bits resolved by the divider, one per back stage
    localparam int Q_BITS = $clog2((IMAGE_COLS > IMAGE_ROWS) ? IMAGE_COLS : IMAGE_ROWS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [IDX_W-1:0] {
        REG_COL_BY_COL = 3'd0,
        REG_COL_BY_ROW = 3'd1,
        REG_COL_OFFSET = 3'd2,
        REG_ROW_BY_COL = 3'd3,
        REG_ROW_BY_ROW = 3'd4,
        REG_ROW_OFFSET = 3'd5,
        REG_DEN_BY_COL = 3'd6,
        REG_DEN_BY_ROW = 3'd7
    } t_reg_idx;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        t_coef a;  // col by col
        t_coef b;  // col by row
        t_coef e;  // col offset
        t_coef d;  // row by col
        t_coef f;  // row by row
        t_coef k;  // row offset
        t_coef g;  // den by col
        t_coef h;  // den by row
    } t_coefs;

    localparam t_coef RST_COL_BY_COL = 32'sd13946263;
    localparam t_coef RST_COL_BY_ROW = -32'sd11530209;
    localparam t_coef RST_COL_OFFSET = 32'sd267658100;
    localparam t_coef RST_ROW_BY_COL = 32'sd164182;
    localparam t_coef RST_ROW_BY_ROW = 32'sd1122517;
    localparam t_coef RST_ROW_OFFSET = 32'sd116272331;
    localparam t_coef RST_DEN_BY_COL = -32'sd2337;
    localparam t_coef RST_DEN_BY_ROW = -32'sd120370;

    typedef struct packed {
        logic [MAG_W-1:0] num_col;
        logic [MAG_W-1:0] num_row;
        logic [MAG_W-1:0] den;
        logic             neg_col;   // quotient sign
        logic             neg_row;
        logic             den_zero;
    } t_job;

endpackage

// File: hdl/homography_source_address.sv
// ----------------------------------------------------------------------------
// homography_source_address
// maps an output pixel through a 3x3 projective matrix to its source pixel
// ----------------------------------------------------------------------------
// Takes one word per clock and gives one word per clock while the output
// is not stalled. A word passes three front stages (multiply, sum,
// sign/magnitude), the job queue, one stage per quotient bit of the pipelined
// restoring divider (Q_BITS, 8 for a 188x120 image) plus its overflow stage,
// and the output register. The four-entry queue lets the
// front keep taking words while the output is stalled; coefficient writes
// must only happen with no word in flight.
module homography_source_address (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hsa_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [hsa_pkg::COEF_W-1:0]       i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [hsa_pkg::DATA_W-1:0]       s_axis_tdata,  // out_col, out_row, pad
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [hsa_pkg::DATA_W-1:0]       m_axis_tdata   // src_col, src_row, in_range
);

    hsa_pkg::t_coefs  r_coef;
    hsa_pkg::t_reg_idx cfg_idx;

    logic          push, pop, full, empty;
    hsa_pkg::t_job fr_job, q_job;

    logic [hsa_pkg::COL_W-1:0] src_col;
    logic [hsa_pkg::ROW_W-1:0] src_row;
    logic                      in_range;

    assign cfg_idx = hsa_pkg::t_reg_idx'(i_cfg_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.a <= hsa_pkg::RST_COL_BY_COL;
            r_coef.b <= hsa_pkg::RST_COL_BY_ROW;
            r_coef.e <= hsa_pkg::RST_COL_OFFSET;
            r_coef.d <= hsa_pkg::RST_ROW_BY_COL;
            r_coef.f <= hsa_pkg::RST_ROW_BY_ROW;
            r_coef.k <= hsa_pkg::RST_ROW_OFFSET;
            r_coef.g <= hsa_pkg::RST_DEN_BY_COL;
            r_coef.h <= hsa_pkg::RST_DEN_BY_ROW;
        end else if (i_cfg_we) begin
            unique case (cfg_idx)
                hsa_pkg::REG_COL_BY_COL: r_coef.a <= i_cfg_data;
                hsa_pkg::REG_COL_BY_ROW: r_coef.b <= i_cfg_data;
                hsa_pkg::REG_COL_OFFSET: r_coef.e <= i_cfg_data;
                hsa_pkg::REG_ROW_BY_COL: r_coef.d <= i_cfg_data;
                hsa_pkg::REG_ROW_BY_ROW: r_coef.f <= i_cfg_data;
                hsa_pkg::REG_ROW_OFFSET: r_coef.k <= i_cfg_data;
                hsa_pkg::REG_DEN_BY_COL: r_coef.g <= i_cfg_data;
                hsa_pkg::REG_DEN_BY_ROW: r_coef.h <= i_cfg_data;
                default:                 r_coef.a <= r_coef.a;
            endcase
        end
    end

    hsa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (r_coef),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_col   (s_axis_tdata[hsa_pkg::COL_W-1:0]),
        .i_row   (s_axis_tdata[hsa_pkg::COL_W +: hsa_pkg::ROW_W]),
        .o_push  (push),
        .o_job   (fr_job),
        .i_full  (full)
    );

    hsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (fr_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_empty (empty)
    );

    hsa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (q_job),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_src_col  (src_col),
        .o_src_row  (src_row),
        .o_in_range (in_range)
    );

    assign m_axis_tdata = {in_range, src_row, src_col};

endmodule

// File: hdl/hsa_front.sv
// ----------------------------------------------------------------------------
// hsa_front
// products, sums and sign/magnitude split of the projective map
// ----------------------------------------------------------------------------
module hsa_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hsa_pkg::t_coefs           i_coef,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [hsa_pkg::COL_W-1:0] i_col,
    input  logic [hsa_pkg::ROW_W-1:0] i_row,
    output logic                      o_push,
    output hsa_pkg::t_job             o_job,
    input  logic                      i_full
);

    localparam int SW = hsa_pkg::SUM_W;
    localparam int MW = hsa_pkg::MAG_W;

    logic r_v1, r_v2, r_v3;
    logic en;

    logic signed [SW-1:0] r_pa, r_pb, r_pd, r_pf, r_pg, r_ph;
    logic signed [SW-1:0] r_ncol, r_nrow, r_den;
    hsa_pkg::t_job        r_job;

    logic signed [SW-1:0] c_ext, r_ext;

    assign en      = !r_v3 || !i_full;
    assign o_ready = en;
    assign o_push  = r_v3 && !i_full;
    assign o_job   = r_job;

    assign c_ext = SW'($signed({1'b0, i_col}));
    assign r_ext = SW'($signed({1'b0, i_row}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa <= SW'(SW'(i_coef.a) * c_ext);
            r_pb <= SW'(SW'(i_coef.b) * r_ext);
            r_pd <= SW'(SW'(i_coef.d) * c_ext);
            r_pf <= SW'(SW'(i_coef.f) * r_ext);
            r_pg <= SW'(SW'(i_coef.g) * c_ext);
            r_ph <= SW'(SW'(i_coef.h) * r_ext);

            r_ncol <= r_pa + r_pb + SW'(i_coef.e);
            r_nrow <= r_pd + r_pf + SW'(i_coef.k);
            r_den  <= r_pg + r_ph + SW'(hsa_pkg::Q_ONE);

            r_job.num_col  <= MW'(r_ncol[SW-1] ? -r_ncol : r_ncol);
            r_job.num_row  <= MW'(r_nrow[SW-1] ? -r_nrow : r_nrow);
            r_job.den      <= MW'(r_den[SW-1] ? -r_den : r_den);
            r_job.neg_col  <= r_ncol[SW-1] ^ r_den[SW-1];
            r_job.neg_row  <= r_nrow[SW-1] ^ r_den[SW-1];
            r_job.den_zero <= (r_den == '0);
        end
    end

endmodule

// File: hdl/hsa_queue.sv
// ----------------------------------------------------------------------------
// hsa_queue
// short job queue between the front and the divider
// ----------------------------------------------------------------------------
module hsa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hsa_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output hsa_pkg::t_job o_job,
    output logic          o_empty
);

    localparam int AW = hsa_pkg::QUEUE_AW;

    hsa_pkg::t_job r_mem [hsa_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(hsa_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

// File: hdl/hsa_back.sv
// ----------------------------------------------------------------------------
// hsa_back
// pipelined restoring divider, one quotient bit per stage, and range check
// ----------------------------------------------------------------------------
module hsa_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hsa_pkg::t_job             i_job,
    input  logic                      i_empty,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [hsa_pkg::COL_W-1:0] o_src_col,
    output logic [hsa_pkg::ROW_W-1:0] o_src_row,
    output logic                      o_in_range
);

    localparam int QB = hsa_pkg::Q_BITS;
    localparam int MW = hsa_pkg::MAG_W;
    localparam int WW = MW + QB;

    logic en;

    logic          r_v      [QB+1];
    logic [MW-1:0] r_rc     [QB+1];
    logic [MW-1:0] r_rr     [QB+1];
    logic [MW-1:0] r_den    [QB+1];
    logic [QB-1:0] r_qc     [QB+1];
    logic [QB-1:0] r_qr     [QB+1];
    logic          r_negc   [QB+1];
    logic          r_negr   [QB+1];
    logic          r_bad    [QB+1];

    logic [MW-1:0] n_rc [QB];
    logic [MW-1:0] n_rr [QB];
    logic [QB-1:0] n_qc [QB];
    logic [QB-1:0] n_qr [QB];

    logic          ovf;
    logic          ok;
    logic          r_ov, r_ok;
    logic [QB-1:0] r_sc, r_sr;

    assign en    = !r_ov || i_ready;
    assign o_pop = en && !i_empty;

    // quotient of 2^QB or more cannot land in the image
    assign ovf = ({{QB{1'b0}}, i_job.num_col} >= {i_job.den, {QB{1'b0}}})
              || ({{QB{1'b0}}, i_job.num_row} >= {i_job.den, {QB{1'b0}}});

    always_comb begin
        for (int s = 0; s < QB; s++) begin
            n_rc[s] = r_rc[s];
            n_rr[s] = r_rr[s];
            n_qc[s] = r_qc[s];
            n_qr[s] = r_qr[s];
            if ({{QB{1'b0}}, r_rc[s]} >= (WW'(r_den[s]) << (QB-1-s))) begin
                n_rc[s] = MW'({{QB{1'b0}}, r_rc[s]} - (WW'(r_den[s]) << (QB-1-s)));
                n_qc[s][QB-1-s] = 1'b1;
            end
            if ({{QB{1'b0}}, r_rr[s]} >= (WW'(r_den[s]) << (QB-1-s))) begin
                n_rr[s] = MW'({{QB{1'b0}}, r_rr[s]} - (WW'(r_den[s]) << (QB-1-s)));
                n_qr[s][QB-1-s] = 1'b1;
            end
        end
    end

    // negative quotient is only acceptable when it truncates to zero
    assign ok = r_v[QB] && !r_bad[QB]
             && (!r_negc[QB] || (r_qc[QB] == '0))
             && (!r_negr[QB] || (r_qr[QB] == '0))
             && (WW'(r_qc[QB]) < WW'(hsa_pkg::IMAGE_COLS))
             && (WW'(r_qr[QB]) < WW'(hsa_pkg::IMAGE_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) r_v[s] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= o_pop;
            for (int s = 0; s < QB; s++) r_v[s+1] <= r_v[s];
            r_ov <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rc[0]   <= i_job.num_col;
            r_rr[0]   <= i_job.num_row;
            r_den[0]  <= i_job.den;
            r_qc[0]   <= '0;
            r_qr[0]   <= '0;
            r_negc[0] <= i_job.neg_col;
            r_negr[0] <= i_job.neg_row;
            r_bad[0]  <= i_job.den_zero || ovf;
            for (int s = 0; s < QB; s++) begin
                r_rc[s+1]   <= n_rc[s];
                r_rr[s+1]   <= n_rr[s];
                r_den[s+1]  <= r_den[s];
                r_qc[s+1]   <= n_qc[s];
                r_qr[s+1]   <= n_qr[s];
                r_negc[s+1] <= r_negc[s];
                r_negr[s+1] <= r_negr[s];
                r_bad[s+1]  <= r_bad[s];
            end
            r_ok <= ok;
            r_sc <= ok ? r_qc[QB] : '0;
            r_sr <= ok ? r_qr[QB] : '0;
        end
    end

    assign o_valid    = r_ov;
    assign o_in_range = r_ok;
    assign o_src_col  = hsa_pkg::COL_W'(r_sc);
    assign o_src_row  = hsa_pkg::ROW_W'(r_sr);

    a_black_is_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_ok) |-> (r_sc == '0 && r_sr == '0))
        else $error("out-of-range word carries a nonzero source");

    a_last_stage_moves : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[QB] && en) |=> r_ov)
        else $error("finished quotient lost before the output register");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !r_ov)
        else $error("output valid straight after reset");

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the homography source address block
// ----------------------------------------------------------------------------
// Loads coefficient sets through the write port while idle, streams output
// pixel coordinates with random gaps and back-pressure, predicts each source
// address with exact 64-bit arithmetic and compares it word by word.
module tb;

    typedef struct packed {
        logic                      in_range;
        logic [hsa_pkg::ROW_W-1:0] src_row;
        logic [hsa_pkg::COL_W-1:0] src_col;
    } t_addr;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [hsa_pkg::IDX_W-1:0]     i_cfg_idx = '0;
    logic [hsa_pkg::COEF_W-1:0]    i_cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [hsa_pkg::DATA_W-1:0]    s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [hsa_pkg::DATA_W-1:0]    m_axis_tdata;

    homography_source_address u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    hsa_pkg::t_coef coefs [hsa_pkg::NUM_REGS];
    logic [14:0]    pixel_q [$];
    t_addr          addr_q [$];
    int             errors = 0;
    int             words_in = 0;
    int             words_out = 0;
    int             hits = 0;
    int             cycles = 0;
    int             hold_off = 0;
    bit             hold_req = 1'b0;
    bit             hold_done = 1'b0;
    bit             calm = 1'b0;
    bit             running = 1'b0;
    bit             s_axis_tready_seen = 1'b0;

    function automatic t_addr map_pixel(logic [7:0] c8, logic [6:0] r8);
        longint c, r, ncol, nrow, den, qc, qr;
        t_addr  res;
        c = c8;
        r = r8;
        ncol = coefs[hsa_pkg::REG_COL_BY_COL] * c + coefs[hsa_pkg::REG_COL_BY_ROW] * r
             + coefs[hsa_pkg::REG_COL_OFFSET];
        nrow = coefs[hsa_pkg::REG_ROW_BY_COL] * c + coefs[hsa_pkg::REG_ROW_BY_ROW] * r
             + coefs[hsa_pkg::REG_ROW_OFFSET];
        den  = coefs[hsa_pkg::REG_DEN_BY_COL] * c + coefs[hsa_pkg::REG_DEN_BY_ROW] * r
             + longint'(hsa_pkg::Q_ONE);
        res = '0;
        if (den != 0) begin
            qc = ncol / den;
            qr = nrow / den;
            if (qc >= 0 && qc < hsa_pkg::IMAGE_COLS && qr >= 0 && qr < hsa_pkg::IMAGE_ROWS) begin
                res.src_col  = qc[hsa_pkg::COL_W-1:0];
                res.src_row  = qr[hsa_pkg::ROW_W-1:0];
                res.in_range = 1'b1;
            end
        end
        return res;
    endfunction

    // monitor: prediction made at acceptance, with the coefficients in force then
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        s_axis_tready_seen <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            addr_q.push_back(map_pixel(s_axis_tdata[7:0], s_axis_tdata[14:8]));
            words_in <= words_in + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_addr got, want;
            got = m_axis_tdata[15:0];
            words_out <= words_out + 1;
            if (addr_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, m_axis_tdata);
                errors <= errors + 1;
            end else begin
                want = addr_q.pop_front();
                if (got.in_range) hits <= hits + 1;
                if (got.src_col !== want.src_col)
                    $display("%0t: src_col exp %0d got %0d", $time, want.src_col, got.src_col);
                if (got.src_row !== want.src_row)
                    $display("%0t: src_row exp %0d got %0d", $time, want.src_row, got.src_row);
                if (got.in_range !== want.in_range)
                    $display("%0t: in_range exp %0d got %0d", $time, want.in_range, got.in_range);
                if (got !== want) errors <= errors + 1;
            end
        end
        if (cycles > 400000) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // sender side
    always @(negedge i_clk) begin
        if (s_axis_tvalid && !s_axis_tready_seen) begin
            // word still on offer
        end else if (running && pixel_q.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {1'b0, pixel_q.pop_front()};
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // receiver side, with one long hold-off counted here
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_off      <= 300;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 30);
        end
    end

    task automatic write_coef(hsa_pkg::t_reg_idx idx, hsa_pkg::t_coef val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        coefs[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain;
        wait (pixel_q.size() == 0 && !s_axis_tvalid);
        wait (addr_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic load_set(hsa_pkg::t_coef a, hsa_pkg::t_coef b, hsa_pkg::t_coef e,
                            hsa_pkg::t_coef d, hsa_pkg::t_coef f, hsa_pkg::t_coef k,
                            hsa_pkg::t_coef g, hsa_pkg::t_coef h);
        write_coef(hsa_pkg::REG_COL_BY_COL, a);
        write_coef(hsa_pkg::REG_COL_BY_ROW, b);
        write_coef(hsa_pkg::REG_COL_OFFSET, e);
        write_coef(hsa_pkg::REG_ROW_BY_COL, d);
        write_coef(hsa_pkg::REG_ROW_BY_ROW, f);
        write_coef(hsa_pkg::REG_ROW_OFFSET, k);
        write_coef(hsa_pkg::REG_DEN_BY_COL, g);
        write_coef(hsa_pkg::REG_DEN_BY_ROW, h);
    endtask

    task automatic random_pixels(int n);
        repeat (n) pixel_q.push_back({7'($urandom), 8'($urandom)});
    endtask

    // small random tweak so the results mostly stay inside the image
    function automatic hsa_pkg::t_coef jitter(hsa_pkg::t_coef base, int span);
        return base + $signed($urandom_range(2 * span)) - span;
    endfunction

    initial begin
        coefs[hsa_pkg::REG_COL_BY_COL] = hsa_pkg::RST_COL_BY_COL;
        coefs[hsa_pkg::REG_COL_BY_ROW] = hsa_pkg::RST_COL_BY_ROW;
        coefs[hsa_pkg::REG_COL_OFFSET] = hsa_pkg::RST_COL_OFFSET;
        coefs[hsa_pkg::REG_ROW_BY_COL] = hsa_pkg::RST_ROW_BY_COL;
        coefs[hsa_pkg::REG_ROW_BY_ROW] = hsa_pkg::RST_ROW_BY_ROW;
        coefs[hsa_pkg::REG_ROW_OFFSET] = hsa_pkg::RST_ROW_OFFSET;
        coefs[hsa_pkg::REG_DEN_BY_COL] = hsa_pkg::RST_DEN_BY_COL;
        coefs[hsa_pkg::REG_DEN_BY_ROW] = hsa_pkg::RST_DEN_BY_ROW;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, field extremes, reset coefficients
        pixel_q = '{15'h0000, {7'd0, 8'd187}, {7'd119, 8'd0}, {7'd119, 8'd187},
                    {7'd127, 8'd255}, {7'd60, 8'd94}, {7'd64, 8'd128}, {7'd1, 8'd1}};
        running = 1'b1;
        drain();
        // identity-like map, then a zero denominator on row 1
        load_set(32'sd16777216, 0, 0, 0, 32'sd16777216, 0, 0, 0);
        pixel_q = '{15'h0000, {7'd119, 8'd187}, {7'd120, 8'd188}, {7'd5, 8'd7}};
        drain();
        load_set(32'sd16777216, 0, 0, 0, 32'sd16777216, 0, 0, -32'sd16777216);
        // den zero at row 1, negative below
        pixel_q = '{{7'd1, 8'd3}, {7'd2, 8'd3}, {7'd0, 8'd3}, {7'd3, 8'd10}};
        drain();
        // register extremes
        load_set(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        pixel_q = '{15'h0000, {7'd127, 8'd255}, {7'd0, 8'd255}, {7'd127, 8'd0}};
        drain();
        load_set(-32'sd16777216, 0, 32'sd3221225, 0, -32'sd16777216, 32'sd2013265,
                 0, 0);
        pixel_q = '{15'h0000, {7'd127, 8'd255}};
        drain();

        // random phases, the long stall in the second
        for (int ph = 0; ph < 6; ph++) begin
            load_set(jitter(hsa_pkg::RST_COL_BY_COL, 1 << 22),
                     jitter(hsa_pkg::RST_COL_BY_ROW, 1 << 22),
                     jitter(hsa_pkg::RST_COL_OFFSET, 1 << 26),
                     jitter(hsa_pkg::RST_ROW_BY_COL, 1 << 20),
                     jitter(hsa_pkg::RST_ROW_BY_ROW, 1 << 21),
                     jitter(hsa_pkg::RST_ROW_OFFSET, 1 << 26),
                     jitter(hsa_pkg::RST_DEN_BY_COL, 1 << 14),
                     jitter(hsa_pkg::RST_DEN_BY_ROW, 1 << 17));
            if (ph == 5) load_set($urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom);
            calm = (ph == 3);
            if (ph == 1) hold_req = 1'b1;
            random_pixels(150);
            drain();
        end
        calm = 1'b0;
        repeat (20) @(posedge i_clk);

        $display("mapped %0d pixels over several coefficient sets, %0d inside the image",
                 words_out, hits);
        if (errors == 0 && addr_q.size() == 0 && words_in == words_out)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

// File: sim.f
hdl/hsa_pkg.sv
hdl/hsa_front.sv
hdl/hsa_queue.sv
hdl/hsa_back.sv
hdl/homography_source_address.sv
bench/tb.sv
